// ----- rtl/dsh_pkg.sv -----
`default_nettype none
package dsh_pkg;
    localparam int HALF_LOG_DEF = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int HGT_W = 24;
    localparam int RGH_W = 16;
    localparam int FAC_W = 16;
    localparam int COORD_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_CORNER_TL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_TR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_BL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_BR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUGHNESS = 3'd4;

    localparam logic [RGH_W-1:0] ROUGHNESS_RESET = 16'h8000;

    // neighbour slots in ascending order
    typedef enum logic [1:0] {
        SLOT_LEFT   = 2'd0,
        SLOT_TOP    = 2'd1,
        SLOT_RIGHT  = 2'd2,
        SLOT_BOTTOM = 2'd3
    } slot_t;
endpackage
`default_nettype wire

// ----- rtl/dsh_in_if.sv -----
`default_nettype none
interface dsh_in_if;
    logic        valid;
    logic        ready;
    logic        start_req;
    logic [15:0] rand_factor;
    logic [1:0]  edge_pick;
    modport source (output valid, start_req, rand_factor, edge_pick, input ready);
    modport sink (input valid, start_req, rand_factor, edge_pick, output ready);
endinterface
`default_nettype wire

// ----- rtl/dsh_out_if.sv -----
`default_nettype none
interface dsh_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  point_x;
    logic [6:0]  point_y;
    logic [23:0] height;
    logic        last;
    logic        ignored;
    modport source (output valid, point_x, point_y, height, last, ignored, input ready);
    modport sink (input valid, point_x, point_y, height, last, ignored, output ready);
endinterface
`default_nettype wire

// ----- rtl/dsh_height_calc.sv -----
`default_nettype none
// two-stage height arithmetic: avg*(1+f*r), rounded to Q.8 and saturated
module dsh_height_calc
(
    input  wire logic                            clk,
    input  wire logic signed [25:0]              sum,
    input  wire logic signed [dsh_pkg::FAC_W-1:0] factor,
    input  wire logic [dsh_pkg::RGH_W-1:0]       rough,
    output logic signed [dsh_pkg::HGT_W-1:0]     height
);
    import dsh_pkg::*;

    logic signed [32:0] rh_reg;
    logic signed [25:0] sum_reg;
    logic signed [33:0] one_rh;
    logic signed [60:0] prod;
    logic signed [60:0] rnd;
    logic signed [27:0] q;

    // first stage: factor times roughness, Q.31
    always_ff @(posedge clk)
    begin
        rh_reg  <= 33'(factor) * $signed({1'b0, rough});
        sum_reg <= sum;
    end

    // second stage: sum*(2^31 + rh), then round to nearest with ties up
    always_comb
    begin
        one_rh = 34'(rh_reg) + 34'sh80000000;
        prod   = 61'(sum_reg) * 61'(one_rh);
        rnd    = prod + 61'sh100000000;
        q      = rnd[60:33];
        if (q > 28'sd8388607)
            height = 24'sh7FFFFF;
        else if (q < -28'sd8388608)
            height = 24'sh800000;
        else
            height = q[23:0];
    end
endmodule
`default_nettype wire

// ----- rtl/diamond_square_height_generator.sv -----
`default_nettype none
// Diamond-square height generator. Each accepted request yields one result: the next
// grid point and its height, in square-pass then diamond-pass order per level. A request
// with start_req set loads the corners (each corner written to memory in turn, four in
// all) and begins a new grid. A point is handled, from one accepted request to the
// next, in these steps: the accept, four reads of the single-port height memory with
// its registered read, a sum, two arithmetic stages, a write-back, raising the result
// and handing it over. Input stays blocked while a result waits. Requests after the
// last point without start_req give ignored = 1 and go straight to the result,
// with no memory access.
module diamond_square_height_generator
#(
    parameter int HALF_LOG = dsh_pkg::HALF_LOG_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [dsh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dsh_pkg::CFG_DATA_W-1:0]    cfg_data,
    dsh_in_if.sink                                 in_ch,
    dsh_out_if.source                              out_ch
);
    import dsh_pkg::*;

    localparam int GMAX  = 1 << (2 * HALF_LOG);
    localparam int SIDE  = GMAX + 1;
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = 2 * HALF_LOG + 2;
    localparam logic [CW-1:0] GMAX_C = CW'(GMAX);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_CORN  = 8'b00000010,
        ST_READ  = 8'b00000100,
        ST_ACC   = 8'b00001000,
        ST_MUL1  = 8'b00010000,
        ST_MUL2  = 8'b00100000,
        ST_WRITE = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [HGT_W-1:0] corner_reg [4];
    logic [RGH_W-1:0] rough_cfg_reg;

    logic [CW-1:0]    span_reg, cx_reg, cy_reg;
    logic             diamond_reg, finished_reg;
    logic [RGH_W-1:0] lrough_reg;
    logic signed [FAC_W-1:0] factor_reg;
    logic [1:0]       pick_reg;
    logic [2:0]       rd_cnt_reg;
    logic [1:0]       corner_cnt_reg;
    logic signed [HGT_W-1:0] nb_reg [4];
    logic signed [HGT_W-1:0] rd_data_reg;
    logic             out_valid_reg;
    logic [COORD_W-1:0] ox_reg, oy_reg;
    logic [HGT_W-1:0] oh_reg;
    logic             olast_reg, oign_reg;

    logic [HGT_W-1:0] mem [DEPTH];
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [HGT_W-1:0] mem_wdata;

    logic signed [HGT_W-1:0] h_res;
    logic signed [25:0]      sum;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                corner_reg[i] <= '0;
            rough_cfg_reg <= ROUGHNESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CORNER_TL: corner_reg[0] <= cfg_data;
                REG_CORNER_TR: corner_reg[1] <= cfg_data;
                REG_CORNER_BL: corner_reg[2] <= cfg_data;
                REG_CORNER_BR: corner_reg[3] <= cfg_data;
                REG_ROUGHNESS: rough_cfg_reg <= cfg_data[RGH_W-1:0];
                default: ;
            endcase
        end
    end

    // neighbour coordinates for read slot k
    function automatic logic [2*CW-1:0] nb_xy(input logic [1:0] k);
        logic [CW-1:0] x, y, xl, xr, yt, yb;
        logic [1:0]    sk;
        x = cx_reg; y = cy_reg;
        xl = x - span_reg; xr = x + span_reg;
        yt = y - span_reg; yb = y + span_reg;
        if (!diamond_reg)
        begin
            unique case (k)
                2'd0: return {xl, yt};
                2'd1: return {xr, yt};
                2'd2: return {xl, yb};
                default: return {xr, yb};
            endcase
        end
        sk = k;
        // missing neighbour on an edge reads an existing one instead
        if (x == '0 && k == SLOT_LEFT) sk = SLOT_TOP;
        else if (x == GMAX_C && k == SLOT_RIGHT) sk = SLOT_TOP;
        else if (x != '0 && x != GMAX_C && y == '0 && k == SLOT_TOP) sk = SLOT_LEFT;
        else if (x != '0 && x != GMAX_C && y == GMAX_C && k == SLOT_BOTTOM) sk = SLOT_LEFT;
        unique case (sk)
            SLOT_LEFT:  return {xl, y};
            SLOT_TOP:   return {x, yt};
            SLOT_RIGHT: return {xr, y};
            default:    return {x, yb};
        endcase
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return AW'(y * SIDE + x);
    endfunction

    // replacement slot chosen by edge_pick
    function automatic logic [1:0] edge_src(input logic [1:0] miss, input logic [1:0] p);
        logic [1:0] pp;
        pp = (p > 2'd2) ? 2'd2 : p;
        unique case (miss)
            SLOT_LEFT:  return 2'd1 + pp;
            SLOT_TOP:   return (pp == 2'd0) ? 2'd0 : 2'd1 + pp;
            SLOT_RIGHT: return (pp == 2'd2) ? 2'd3 : pp;
            default:    return pp;
        endcase
    endfunction

    // sum of neighbours, substituting the missing edge slot
    always_comb
    begin
        logic signed [HGT_W-1:0] p [4];
        for (int i = 0; i < 4; i++)
            p[i] = nb_reg[i];
        if (diamond_reg)
        begin
            if (cx_reg == '0) p[0] = nb_reg[edge_src(SLOT_LEFT, pick_reg)];
            else if (cx_reg == GMAX_C) p[2] = nb_reg[edge_src(SLOT_RIGHT, pick_reg)];
            else if (cy_reg == '0) p[1] = nb_reg[edge_src(SLOT_TOP, pick_reg)];
            else if (cy_reg == GMAX_C) p[3] = nb_reg[edge_src(SLOT_BOTTOM, pick_reg)];
        end
        sum = 26'(p[0]) + 26'(p[1]) + 26'(p[2]) + 26'(p[3]);
    end

    dsh_height_calc u_calc
    (
        .clk    (clk),
        .sum    (sum),
        .factor (factor_reg),
        .rough  (lrough_reg),
        .height (h_res)
    );

    // memory port control
    always_comb
    begin
        logic [2*CW-1:0] xy;
        xy = nb_xy(rd_cnt_reg[1:0]);
        mem_we = 1'b0;
        mem_wdata = oh_reg;
        mem_addr = addr_of(xy[2*CW-1:CW], xy[CW-1:0]);
        if (state_reg == ST_CORN)
        begin
            mem_we = 1'b1;
            mem_wdata = corner_reg[corner_cnt_reg];
            mem_addr = addr_of(corner_cnt_reg[0] ? GMAX_C : '0,
                               corner_cnt_reg[1] ? GMAX_C : '0);
        end
        else if (state_reg == ST_WRITE)
        begin
            mem_we = 1'b1;
            mem_wdata = oh_reg;
            mem_addr = addr_of(cx_reg, cy_reg);
        end
    end

    // height memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_ch.valid && !out_valid_reg)
                begin
                    if (in_ch.start_req) state_next = ST_CORN;
                    else if (finished_reg) state_next = ST_OUT;
                    else state_next = ST_READ;
                end
            ST_CORN:  if (corner_cnt_reg == 2'd3) state_next = ST_READ;
            ST_READ:  if (rd_cnt_reg == 3'd4) state_next = ST_ACC;
            ST_ACC:   state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;

    // sequencer, cursor and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            span_reg       <= CW'(GMAX / 2);
            diamond_reg    <= 1'b0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            lrough_reg     <= '0;
            finished_reg   <= 1'b1;
            rd_cnt_reg     <= '0;
            corner_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
            olast_reg      <= 1'b0;
            oign_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_ch.valid && !out_valid_reg)
                    begin
                        factor_reg     <= in_ch.rand_factor;
                        pick_reg       <= in_ch.edge_pick;
                        rd_cnt_reg     <= '0;
                        corner_cnt_reg <= '0;
                        oign_reg       <= !in_ch.start_req && finished_reg;
                        olast_reg      <= 1'b0;
                        ox_reg         <= '0;
                        oy_reg         <= '0;
                        oh_reg         <= '0;
                        if (in_ch.start_req)
                        begin
                            span_reg     <= CW'(GMAX / 2);
                            diamond_reg  <= 1'b0;
                            cx_reg       <= CW'(GMAX / 2);
                            cy_reg       <= CW'(GMAX / 2);
                            lrough_reg   <= rough_cfg_reg;
                            finished_reg <= 1'b0;
                        end
                    end
                ST_CORN: corner_cnt_reg <= corner_cnt_reg + 2'd1;
                ST_READ:
                begin
                    if (rd_cnt_reg != 3'd0)
                        nb_reg[rd_cnt_reg[1:0] - 2'd1] <= rd_data_reg;
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                end
                ST_MUL2:
                begin
                    oh_reg <= h_res;
                    ox_reg <= COORD_W'(cx_reg);
                    oy_reg <= COORD_W'(cy_reg);
                end
                ST_WRITE:
                begin
                    // cursor advance
                    if (!diamond_reg)
                    begin
                        if (cx_reg + (span_reg << 1) >= GMAX_C)
                        begin
                            if (cy_reg + (span_reg << 1) >= GMAX_C)
                            begin
                                diamond_reg <= 1'b1;
                                cy_reg <= '0;
                                cx_reg <= span_reg;
                            end
                            else
                            begin
                                cx_reg <= span_reg;
                                cy_reg <= cy_reg + (span_reg << 1);
                            end
                        end
                        else
                            cx_reg <= cx_reg + (span_reg << 1);
                    end
                    else if (cx_reg + (span_reg << 1) > GMAX_C)
                    begin
                        if (cy_reg + span_reg > GMAX_C)
                        begin
                            span_reg    <= span_reg >> 1;
                            lrough_reg  <= lrough_reg >> 1;
                            diamond_reg <= 1'b0;
                            if (span_reg == CW'(1))
                            begin
                                cx_reg <= '0;
                                cy_reg <= '0;
                                finished_reg <= 1'b1;
                                olast_reg <= 1'b1;
                            end
                            else
                            begin
                                cx_reg <= span_reg >> 1;
                                cy_reg <= span_reg >> 1;
                            end
                        end
                        else
                        begin
                            cy_reg <= cy_reg + span_reg;
                            // (y+s) mod 2s with power-of-two span
                            cx_reg <= (cy_reg + (span_reg << 1)) & ((span_reg << 1) - CW'(1));
                        end
                    end
                    else
                        cx_reg <= cx_reg + (span_reg << 1);
                end
                ST_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.point_x = ox_reg;
    assign out_ch.point_y = oy_reg;
    assign out_ch.height  = oh_reg;
    assign out_ch.last    = olast_reg;
    assign out_ch.ignored = oign_reg;

    // no new request while a result waits
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ch.ready)
        else $error("request accepted while result pending");
    // ignored results carry no point
    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && oign_reg) |-> (oh_reg == '0 && !olast_reg))
        else $error("ignored result not cleared");
    // a last point leaves the generator finished
    a_last_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && olast_reg) |-> finished_reg)
        else $error("last without finish");
endmodule
`default_nettype wire
